/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

// Same-cycle implication that is checked through reset as well.
`define HBD_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("deframer check failed");

`endif

/* rtl/core/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// hbd_pkg
// Types, codes and helper functions of the HTTP body deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

    localparam int unsigned COUNT_W = 32;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [COUNT_W-1:0] SIZE_LIMIT = 32'h0800_0000;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;

    localparam logic REG_FRAMING_MODE   = 1'b0;
    localparam logic REG_CONTENT_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_CLOSE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_LENGTH  = 2'd0,
        MODE_CHUNKED = 2'd1,
        MODE_CLOSE   = 2'd2,
        MODE_NO_BODY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_LEN     = 4'd0,
        PH_CSIZE   = 4'd1,
        PH_CDATA   = 4'd2,
        PH_CCRLF   = 4'd3,
        PH_TRAILER = 4'd4,
        PH_CLOSE   = 4'd5,
        PH_DONE    = 4'd6,
        PH_ERROR   = 4'd7,
        PH_TRUNC   = 4'd8
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [COUNT_W-1:0] count;
        logic               digit_seen;
        logic               in_ext;
        logic               trailer_nonempty;
    } t_body_state;

    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_out;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [BYTE_W-1:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_status status_of(input t_phase ph);
        t_status s;
        unique case (ph)
            PH_DONE:  s = ST_COMPLETE;
            PH_ERROR: s = ST_ERROR;
            PH_TRUNC: s = ST_TRUNC;
            default:  s = ST_RUNNING;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hbd_step.sv */
// ----------------------------------------------------------------------------
// hbd_step
// Next body state and result for one command or received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_step (
    input  wire hbd_pkg::t_body_state               i_state,
    input  wire logic [1:0]                         i_opcode,
    input  wire logic [hbd_pkg::BYTE_W-1:0]         i_rx_byte,
    input  wire logic [1:0]                         i_framing_mode,
    input  wire logic [hbd_pkg::COUNT_W-1:0]        i_content_length,
    output hbd_pkg::t_body_state                    o_state,
    output hbd_pkg::t_result                        o_result
);

    hbd_pkg::t_hex hex;
    logic          finished;
    logic          take;

    assign hex      = hbd_pkg::hex_digit(i_rx_byte);
    assign finished = (i_state.phase == hbd_pkg::PH_DONE) ||
                      (i_state.phase == hbd_pkg::PH_ERROR) ||
                      (i_state.phase == hbd_pkg::PH_TRUNC);

    always_comb begin
        o_state = i_state;
        take    = 1'b0;
        unique case (i_opcode)
            hbd_pkg::OP_START: begin
                o_state.count            = '0;
                o_state.digit_seen       = 1'b0;
                o_state.in_ext           = 1'b0;
                o_state.trailer_nonempty = 1'b0;
                unique case (hbd_pkg::t_mode'(i_framing_mode))
                    hbd_pkg::MODE_LENGTH: begin
                        o_state.count = i_content_length;
                        o_state.phase = (i_content_length != '0) ? hbd_pkg::PH_LEN
                                                                 : hbd_pkg::PH_DONE;
                    end
                    hbd_pkg::MODE_CHUNKED: o_state.phase = hbd_pkg::PH_CSIZE;
                    hbd_pkg::MODE_CLOSE:   o_state.phase = hbd_pkg::PH_CLOSE;
                    default:               o_state.phase = hbd_pkg::PH_DONE;
                endcase
            end
            hbd_pkg::OP_BYTE: begin
                unique case (i_state.phase)
                    hbd_pkg::PH_LEN, hbd_pkg::PH_CDATA: begin
                        take = 1'b1;
                        if (i_state.count <= 32'd1) begin
                            o_state.count = '0;
                            o_state.phase = (i_state.phase == hbd_pkg::PH_LEN)
                                          ? hbd_pkg::PH_DONE : hbd_pkg::PH_CCRLF;
                        end else begin
                            o_state.count = i_state.count - 32'd1;
                        end
                    end
                    hbd_pkg::PH_CLOSE: take = 1'b1;
                    hbd_pkg::PH_CSIZE: begin
                        priority if (i_rx_byte == hbd_pkg::CH_LF) begin
                            if (!i_state.digit_seen) begin
                                o_state.phase = hbd_pkg::PH_ERROR;
                            end else begin
                                o_state.phase = (i_state.count != '0) ? hbd_pkg::PH_CDATA
                                                                      : hbd_pkg::PH_TRAILER;
                                o_state.digit_seen = 1'b0;
                                o_state.in_ext     = 1'b0;
                            end
                        end else if (i_state.in_ext || i_rx_byte == hbd_pkg::CH_CR) begin
                            o_state.in_ext = i_state.in_ext;
                        end else if (i_rx_byte == hbd_pkg::CH_SEMI) begin
                            o_state.in_ext = 1'b1;
                        end else if (hex.ok && i_state.count < hbd_pkg::SIZE_LIMIT) begin
                            o_state.count      = {i_state.count[hbd_pkg::COUNT_W-5:0],
                                                  hex.value};
                            o_state.digit_seen = 1'b1;
                        end else if (i_rx_byte != hbd_pkg::CH_SPACE &&
                                     i_rx_byte != hbd_pkg::CH_TAB) begin
                            o_state.phase = hbd_pkg::PH_ERROR;
                        end
                    end
                    hbd_pkg::PH_CCRLF: begin
                        if (i_rx_byte == hbd_pkg::CH_LF) begin
                            o_state.phase = hbd_pkg::PH_CSIZE;
                        end else if (i_rx_byte != hbd_pkg::CH_CR) begin
                            o_state.phase = hbd_pkg::PH_ERROR;
                        end
                    end
                    hbd_pkg::PH_TRAILER: begin
                        if (i_rx_byte == hbd_pkg::CH_LF) begin
                            if (!i_state.trailer_nonempty) begin
                                o_state.phase = hbd_pkg::PH_DONE;
                            end
                            o_state.trailer_nonempty = 1'b0;
                        end else if (i_rx_byte != hbd_pkg::CH_CR) begin
                            o_state.trailer_nonempty = 1'b1;
                        end
                    end
                    default: take = 1'b0;
                endcase
            end
            hbd_pkg::OP_CLOSE: begin
                if (i_state.phase == hbd_pkg::PH_CLOSE) begin
                    o_state.phase = hbd_pkg::PH_DONE;
                end else if (!finished) begin
                    o_state.phase = hbd_pkg::PH_TRUNC;
                end
            end
            default: o_state = i_state;
        endcase
    end

    assign o_result.data_valid = take;
    assign o_result.data_out   = take ? i_rx_byte : '0;
    assign o_result.status     = hbd_pkg::status_of(o_state.phase);

endmodule

`default_nettype wire

/* rtl/core/http_body_deframer_core.sv */
// ----------------------------------------------------------------------------
// http_body_deframer_core
// Results are registered in the output entry, or the skid entry if it is held.
// Throughput: one item per cycle unless stalled, via single-pass step logic.
// A two-entry output stage lets one more item in while a result waits.
// Reset leaves the body complete, the registers at zero and both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module http_body_deframer_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic [hbd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_data_valid,
    output logic [hbd_pkg::BYTE_W-1:0]          o_data_out,
    output logic [1:0]                          o_stream_status
);

    logic [1:0]                     r_framing_mode;
    logic [hbd_pkg::COUNT_W-1:0]    r_content_length;
    hbd_pkg::t_body_state           r_state;
    hbd_pkg::t_body_state           n_state;
    hbd_pkg::t_result               n_result;
    hbd_pkg::t_result               r_out;
    hbd_pkg::t_result               r_skid;
    logic                           r_out_valid;
    logic                           r_skid_valid;
    logic                           in_acc;
    logic                           out_free;
    logic                           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            hbd_pkg::REG_FRAMING_MODE: prdata = {30'd0, r_framing_mode};
            default:                   prdata = r_content_length;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_framing_mode   <= 2'd0;
            r_content_length <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                hbd_pkg::REG_FRAMING_MODE: r_framing_mode   <= pwdata[1:0];
                default:                   r_content_length <= pwdata;
            endcase
        end
    end

    hbd_step u_step (
        .i_state          (r_state),
        .i_opcode         (i_opcode),
        .i_rx_byte        (i_rx_byte),
        .i_framing_mode   (r_framing_mode),
        .i_content_length (r_content_length),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= hbd_pkg::PH_DONE;
            r_state.count            <= '0;
            r_state.digit_seen       <= 1'b0;
            r_state.in_ext           <= 1'b0;
            r_state.trailer_nonempty <= 1'b0;
            r_out_valid              <= 1'b0;
            r_skid_valid             <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid  <= r_skid_valid || in_acc;
                r_skid_valid <= 1'b0;
            end else if (in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_data_valid    = r_out.data_valid;
    assign o_data_out      = r_out.data_out;
    assign o_stream_status = r_out.status;

endmodule

`default_nettype wire

/* rtl/core/hbd_checker.sv */
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hbd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic                        o_data_valid,
    input wire logic [hbd_pkg::BYTE_W-1:0]  o_data_out,
    input wire logic [1:0]                  o_stream_status
);

    logic out_held;
    logic no_payload_status;

    assign out_held          = o_out_valid && i_out_stall;
    assign no_payload_status = (o_stream_status == hbd_pkg::ST_ERROR) ||
                               (o_stream_status == hbd_pkg::ST_TRUNC);

    `HBD_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_data_out) && $stable(o_stream_status))
    `HBD_ASSERT_NOW(a_empty_byte_zero, i_clk, i_rst_n, o_out_valid && !o_data_valid, o_data_out == '0)
    `HBD_ASSERT_NOW(a_no_data_after_fault, i_clk, i_rst_n, o_out_valid && no_payload_status, !o_data_valid)
    `HBD_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n), !o_out_valid && !o_in_stall)

endmodule

bind http_body_deframer_core hbd_checker u_hbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_data_valid    (o_data_valid),
    .o_data_out      (o_data_out),
    .o_stream_status (o_stream_status)
);

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// HTTP body deframer testbench
// Drives start commands, body bytes and close events into the deframer, with
// random gaps on the input side and random stalls on the result side. A
// model of the framing phases inside the bench predicts every result, and
// each result is checked in order against that prediction. Directed bodies
// come first, then random length, chunked, close-delimited and empty bodies.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbd_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         RANDOM_ITEMS = 1200;
    localparam int         CALM_ITEMS   = 200;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         REPORT_MAX   = 10;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] value;
    } t_beat;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = 3'd0;
    logic [31:0]       pwdata      = 32'd0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_opcode    = OP_START;
    logic [BYTE_W-1:0] i_rx_byte   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_data_valid;
    logic [BYTE_W-1:0] o_data_out;
    logic [1:0]        o_stream_status;

    // Mirror of the registers and of the framing state.
    t_mode              cfg_mode     = MODE_LENGTH;
    logic [COUNT_W-1:0] cfg_length   = '0;
    t_phase             body_ph      = PH_DONE;
    logic [COUNT_W-1:0] left_count   = '0;
    logic               digit_seen   = 1'b0;
    logic               in_ext       = 1'b0;
    logic               trailer_text = 1'b0;

    t_result expected_results[$];
    t_beat   body_beats[$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      cycle_count = 0;
    bit      idle_en     = 1'b1;
    int      hold_seq    = 0;
    int      hold_seen   = 0;
    int      hold_left   = 0;
    int      stall_left  = 0;

    http_body_deframer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_valid   (o_data_valid),
        .o_data_out     (o_data_out),
        .o_stream_status(o_stream_status)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic t_status status_for(input t_phase ph);
        case (ph)
            PH_DONE:  return ST_COMPLETE;
            PH_ERROR: return ST_ERROR;
            PH_TRUNC: return ST_TRUNC;
            default:  return ST_RUNNING;
        endcase
    endfunction

    // Advances the framing state by one beat and returns the result it gives.
    function automatic t_result deframe_step(input logic [1:0] op, input logic [BYTE_W-1:0] c);
        t_result    r;
        logic [4:0] nib;
        logic       payload;
        payload = 1'b0;
        nib = nibble_of(c);
        case (op)
            OP_START: begin
                left_count   = '0;
                digit_seen   = 1'b0;
                in_ext       = 1'b0;
                trailer_text = 1'b0;
                case (cfg_mode)
                    MODE_LENGTH: begin
                        left_count = cfg_length;
                        if (cfg_length != 0) body_ph = PH_LEN;
                        else body_ph = PH_DONE;
                    end
                    MODE_CHUNKED: body_ph = PH_CSIZE;
                    MODE_CLOSE:   body_ph = PH_CLOSE;
                    default:      body_ph = PH_DONE;
                endcase
            end
            OP_BYTE: begin
                case (body_ph)
                    PH_LEN, PH_CDATA: begin
                        payload = 1'b1;
                        if (left_count <= 1) begin
                            left_count = '0;
                            if (body_ph == PH_LEN) body_ph = PH_DONE;
                            else body_ph = PH_CCRLF;
                        end else begin
                            left_count = left_count - 1;
                        end
                    end
                    PH_CLOSE: payload = 1'b1;
                    PH_CSIZE: begin
                        if (c == CH_LF) begin
                            if (!digit_seen) begin
                                body_ph = PH_ERROR;
                            end else begin
                                if (left_count != 0) body_ph = PH_CDATA;
                                else body_ph = PH_TRAILER;
                                digit_seen = 1'b0;
                                in_ext     = 1'b0;
                            end
                        end else if (in_ext || c == CH_CR) begin
                        end else if (c == CH_SEMI) begin
                            in_ext = 1'b1;
                        end else if (nib[4] && left_count < SIZE_LIMIT) begin
                            left_count = {left_count[COUNT_W-5:0], nib[3:0]};
                            digit_seen = 1'b1;
                        end else if (c != CH_SPACE && c != CH_TAB) begin
                            body_ph = PH_ERROR;
                        end
                    end
                    PH_CCRLF: begin
                        if (c == CH_LF) body_ph = PH_CSIZE;
                        else if (c != CH_CR) body_ph = PH_ERROR;
                    end
                    PH_TRAILER: begin
                        if (c == CH_LF) begin
                            if (!trailer_text) body_ph = PH_DONE;
                            trailer_text = 1'b0;
                        end else if (c != CH_CR) begin
                            trailer_text = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_CLOSE: begin
                if (body_ph == PH_CLOSE) body_ph = PH_DONE;
                else if (body_ph < PH_DONE) body_ph = PH_TRUNC;
            end
            default: begin
            end
        endcase
        r.data_valid = payload;
        r.data_out   = payload ? c : '0;
        r.status     = status_for(body_ph);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(deframe_step(i_opcode, i_rx_byte));
            end
            if (o_out_valid && !i_out_stall) begin
                seen.data_valid = o_data_valid;
                seen.data_out   = o_data_out;
                seen.status     = t_status'(o_stream_status);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("unexpected result: valid %0b data %02h status %0d",
                                 seen.data_valid, seen.data_out, seen.status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (seen.data_valid !== want.data_valid || seen.data_out !== want.data_out ||
                        seen.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display({"mismatch: expected valid %0b data %02h status %0d, ",
                                      "got valid %0b data %02h status %0d"},
                                     want.data_valid, want.data_out, want.status,
                                     seen.data_valid, seen.data_out, seen.status);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[http_body_deframer_core] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [BYTE_W-1:0] value);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAMING_MODE) cfg_mode = t_mode'(value[1:0]);
        else cfg_length = value;
    endtask

    task automatic add_beat(input logic [1:0] op, input logic [BYTE_W-1:0] value);
        t_beat b;
        b.op    = op;
        b.value = value;
        body_beats.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_beat(OP_BYTE, s[i]);
    endtask

    task automatic add_crlf();
        add_beat(OP_BYTE, CH_CR);
        add_beat(OP_BYTE, CH_LF);
    endtask

    task automatic send_beats();
        foreach (body_beats[i]) send_item(body_beats[i].op, body_beats[i].value);
        body_beats.delete();
    endtask

    function automatic logic [BYTE_W-1:0] line_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 254));
        if (b >= CH_LF) b = b + 8'd1;
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] filler();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    task automatic add_size_line(input int n);
        string digits;
        digits = $sformatf("%0h", n);
        if ($urandom_range(0, 1)) digits = digits.toupper();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_text("0");
        for (int i = 0; i < digits.len(); i++) begin
            add_beat(OP_BYTE, digits[i]);
            if ($urandom_range(0, 7) == 0) add_beat(OP_BYTE, filler());
        end
        if ($urandom_range(0, 4) == 0) begin
            add_beat(OP_BYTE, CH_SEMI);
            repeat ($urandom_range(0, 5)) add_beat(OP_BYTE, line_byte());
        end
        if ($urandom_range(0, 4) != 0) add_beat(OP_BYTE, CH_CR);
        add_beat(OP_BYTE, CH_LF);
    endtask

    task automatic build_chunked();
        int          chunk_len;
        int          cut;
        logic [31:0] big;
        if ($urandom_range(0, 11) == 0) begin
            big = $urandom_range(0, 1) ? $urandom() : 32'h07FF_FFF0 + $urandom_range(0, 31);
            add_text($sformatf("%h", big));
            add_crlf();
            repeat ($urandom_range(0, 10)) add_beat(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
            add_beat(OP_CLOSE, BYTE_W'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            chunk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300)
                                                    : $urandom_range(1, 12);
            add_size_line(chunk_len);
            repeat (chunk_len) add_beat(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) != 0) add_beat(OP_BYTE, CH_CR);
            add_beat(OP_BYTE, CH_LF);
        end
        add_size_line(0);
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 6)) add_beat(OP_BYTE, line_byte());
            add_crlf();
        end
        add_crlf();
        case ($urandom_range(0, 9))
            0: begin
                cut = $urandom_range(0, body_beats.size() - 1);
                body_beats[cut].value = BYTE_W'($urandom_range(0, 255));
            end
            1: begin
                cut = $urandom_range(0, body_beats.size() - 1);
                while (body_beats.size() > cut) void'(body_beats.pop_back());
                add_beat(OP_CLOSE, BYTE_W'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
    endtask

    task automatic test_idle_phase();
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_CLOSE, 8'h00);
        send_item(OP_UNUSED, 8'hA5);
    endtask

    task automatic test_empty_bodies();
        write_reg(REG_FRAMING_MODE, 32'(MODE_NO_BODY));
        send_item(OP_START, 8'h00);
        write_reg(REG_FRAMING_MODE, 32'(MODE_LENGTH));
        write_reg(REG_CONTENT_LENGTH, 32'd0);
        send_item(OP_START, 8'hFF);
        send_item(OP_BYTE, 8'h00);
    endtask

    task automatic test_length_body();
        write_reg(REG_CONTENT_LENGTH, 32'd3);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h00);
        // Register writes in the middle of a body wait for the next start.
        write_reg(REG_CONTENT_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_FRAMING_MODE, 32'(MODE_CHUNKED));
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, 8'h0A);
        write_reg(REG_FRAMING_MODE, 32'(MODE_LENGTH));
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_CLOSE, 8'h00);
        send_item(OP_CLOSE, 8'h00);
        send_item(OP_BYTE, 8'h11);
    endtask

    task automatic test_close_delimited();
        write_reg(REG_FRAMING_MODE, 32'(MODE_CLOSE));
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h0A);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_CLOSE, 8'h00);
    endtask

    task automatic test_chunked_body();
        write_reg(REG_FRAMING_MODE, 32'(MODE_CHUNKED));
        add_beat(OP_START, 8'h00);
        add_text("1");
        add_beat(OP_BYTE, CH_SPACE);
        add_beat(OP_BYTE, CH_TAB);
        add_text(";x");
        add_crlf();
        add_text("Z");
        add_beat(OP_BYTE, CH_LF);
        add_text("0");
        add_crlf();
        add_text("H");
        add_crlf();
        add_crlf();
        send_beats();
    endtask

    task automatic test_framing_errors();
        add_beat(OP_START, 8'h00);
        add_beat(OP_BYTE, CH_LF);
        add_text("1");
        add_beat(OP_START, 8'h00);
        add_text("80000000");
        add_beat(OP_START, 8'h00);
        add_text("1");
        add_crlf();
        add_text("AX");
        add_beat(OP_START, 8'h00);
        add_text("g");
        add_beat(OP_START, 8'h00);
        add_text("2");
        add_beat(OP_CLOSE, 8'h00);
        send_beats();
    endtask

    task automatic test_back_pressure();
        write_reg(REG_FRAMING_MODE, 32'(MODE_CLOSE));
        idle_en = 1'b0;
        hold_seq++;
        add_beat(OP_START, 8'h00);
        repeat (40) add_beat(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
        add_beat(OP_CLOSE, 8'h00);
        send_beats();
        idle_en = 1'b1;
    endtask

    task automatic test_random_bodies();
        int          first;
        int          pick;
        int          n;
        logic [31:0] length;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            idle_en = (items_sent - first) < (RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick < 9) write_reg(REG_FRAMING_MODE, 32'(MODE_CHUNKED));
                else if (pick < 13) write_reg(REG_FRAMING_MODE, 32'(MODE_LENGTH));
                else if (pick < 17) write_reg(REG_FRAMING_MODE, 32'(MODE_CLOSE));
                else write_reg(REG_FRAMING_MODE, 32'(MODE_NO_BODY));
                if (cfg_mode == MODE_LENGTH || $urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 9))
                        0:       length = 32'hFFFF_FFFF;
                        1:       length = $urandom();
                        2:       length = 32'd0;
                        default: length = $urandom_range(1, 24);
                    endcase
                    write_reg(REG_CONTENT_LENGTH, length);
                end
            end
            if ($urandom_range(0, 11) != 0) add_beat(OP_START, BYTE_W'($urandom_range(0, 255)));
            case (cfg_mode)
                MODE_LENGTH: begin
                    n = $urandom_range(0, 28);
                    if (cfg_length <= 28 && $urandom_range(0, 1)) n = cfg_length;
                    repeat (n) add_beat(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                    if ($urandom_range(0, 3) == 0) begin
                        add_beat(OP_CLOSE, BYTE_W'($urandom_range(0, 255)));
                    end
                end
                MODE_CHUNKED: build_chunked();
                MODE_CLOSE: begin
                    repeat ($urandom_range(0, 20)) begin
                        add_beat(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                    end
                    if ($urandom_range(0, 4) != 0) begin
                        add_beat(OP_CLOSE, BYTE_W'($urandom_range(0, 255)));
                    end
                end
                default: begin
                    repeat ($urandom_range(0, 3)) begin
                        add_beat(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                    end
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    add_beat(2'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
                end
            end
            send_beats();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_phase();
        test_empty_bodies();
        test_length_body();
        test_close_delimited();
        test_chunked_body();
        test_framing_errors();
        test_back_pressure();
        test_random_bodies();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[http_body_deframer_core] OK");
        end else begin
            $display("[http_body_deframer_core] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hbd_pkg.sv
rtl/core/hbd_step.sv
rtl/core/http_body_deframer_core.sv
rtl/core/hbd_checker.sv
bench/testbench.sv
